FILE: rtl/core/ibw_pkg.sv
// ibw_pkg: constants, configuration struct and helpers shared by the
// inverse-distance blend weight pipeline. No dependencies.
package ibw_pkg;

	localparam int DEF_NODE_COUNT = 4;
	localparam int FIELD_COUNT    = 4;

	localparam int COORD_W  = 16;
	localparam int POS_W    = 32;
	localparam int ACTIVE_W = 3;
	localparam int SQ_W     = 31;
	localparam int DIST_W   = 32;
	localparam int RAW_W    = 30;
	localparam int PAIR_W   = 31;
	localparam int SUM_W    = 32;
	localparam int WEIGHT_W = 16;

	localparam logic [COORD_W-1:0] Q_ONE       = 16'd32768;
	localparam logic [DIST_W-1:0]  MIN_DIST_SQ = 32'd1074;
	// top bits of 2^40 that sit above the 30 computed quotient bits
	localparam logic [DIST_W-1:0]  RECIP_INIT  = 32'd1024;

	localparam int FRONT_STAGES = 4;
	localparam int RECIP_STAGES = RAW_W;
	localparam int SUM_STAGES   = 2;
	localparam int NORM_STAGES  = WEIGHT_W;
	localparam int PIPE_DEPTH   = FRONT_STAGES + RECIP_STAGES + SUM_STAGES + NORM_STAGES;

	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_NODE_A = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_NODE_B = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_NODE_C = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_NODE_D = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ACTIVE = 3'd4;

	localparam logic [POS_W-1:0]    NODE_A_RST = 32'h0000_0000;
	localparam logic [POS_W-1:0]    NODE_B_RST = 32'h0000_8000;
	localparam logic [POS_W-1:0]    NODE_C_RST = 32'h8000_0000;
	localparam logic [POS_W-1:0]    NODE_D_RST = 32'h8000_8000;
	localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 3'd4;

	typedef struct packed {
		logic [FIELD_COUNT-1:0][POS_W-1:0] node_pos;
		logic [ACTIVE_W-1:0]               active;
	} cfg_t;

	typedef logic [FIELD_COUNT-1:0][WEIGHT_W-1:0] weights_t;

	function automatic logic [COORD_W-1:0] clamp_unit(input logic [COORD_W-1:0] v);
		return (v > Q_ONE) ? Q_ONE : v;
	endfunction

endpackage

FILE: rtl/core/inverse_distance_blend_weights_unit.sv
// inverse_distance_blend_weights_unit: top level of the blend weight pipeline.
// Depends on ibw_pkg, ibw_cfg_regs, ibw_recip_div, ibw_norm_div, ibw_flow_ctrl.
//
//   channel   beat                    handshake
//   in        cursor_x, cursor_y      in_valid / in_stall
//   out       weight_a .. weight_d    out_valid / out_stall
//   config    APB write / read        psel, penable, pwrite, pready
//
// one beat per cycle sustained while the skid entry is empty
// 4 front stages, 30 reciprocal divider stages, 2 sum stages, 16 normalising
// divider stages; each divider stage holds one compare and subtract per lane and
// the third front stage the multipliers; one skid entry backs the output register
// and the pipeline freezes while it is full, resuming in the next cycle once taken
// reset clears valid bits and restores the node registers; no clearing pass
module inverse_distance_blend_weights_unit #(
	parameter int NODE_COUNT = ibw_pkg::DEF_NODE_COUNT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ibw_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [ibw_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [ibw_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [ibw_pkg::COORD_W-1:0]     cursor_x,
	input  logic [ibw_pkg::COORD_W-1:0]     cursor_y,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [ibw_pkg::WEIGHT_W-1:0]    weight_a,
	output logic [ibw_pkg::WEIGHT_W-1:0]    weight_b,
	output logic [ibw_pkg::WEIGHT_W-1:0]    weight_c,
	output logic [ibw_pkg::WEIGHT_W-1:0]    weight_d
);
	import ibw_pkg::*;

	localparam logic [ACTIVE_W-1:0] NODE_CNT_A = ACTIVE_W'(NODE_COUNT);

	cfg_t                cfg;
	logic                advance;
	logic [ACTIVE_W-1:0] eff_count;

	logic [COORD_W-1:0]  cx_s1;
	logic [COORD_W-1:0]  cy_s1;
	logic [COORD_W-1:0]  dx_s2   [NODE_COUNT];
	logic [COORD_W-1:0]  dy_s2   [NODE_COUNT];
	logic [SQ_W-1:0]     sqx_s3  [NODE_COUNT];
	logic [SQ_W-1:0]     sqy_s3  [NODE_COUNT];
	logic [DIST_W-1:0]   d2_s4   [NODE_COUNT];
	logic [RAW_W-1:0]    raw_div [NODE_COUNT];
	logic [RAW_W-1:0]    raw_pad [FIELD_COUNT];
	logic [RAW_W-1:0]    raw_s35 [NODE_COUNT];
	logic [PAIR_W-1:0]   pair_s35 [2];
	logic [RAW_W-1:0]    raw_s36 [NODE_COUNT];
	logic [SUM_W-1:0]    sum_s36;
	logic [WEIGHT_W-1:0] norm_quo [NODE_COUNT];
	weights_t            weight_pad;
	weights_t            out_data;

	ibw_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	always_comb begin
		if (cfg.active < 3'd2) begin
			eff_count = 3'd2;
		end else if (cfg.active > NODE_CNT_A) begin
			eff_count = NODE_CNT_A;
		end else begin
			eff_count = cfg.active;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cx_s1 <= clamp_unit(cursor_x);
			cy_s1 <= clamp_unit(cursor_y);
		end
	end

	for (genvar l = 0; l < NODE_COUNT; l++) begin : g_lane
		logic [COORD_W-1:0] nx;
		logic [COORD_W-1:0] ny;
		logic [DIST_W-1:0]  prod_x;
		logic [DIST_W-1:0]  prod_y;
		logic [DIST_W-1:0]  d2_raw;

		assign nx     = clamp_unit(cfg.node_pos[l][COORD_W-1:0]);
		assign ny     = clamp_unit(cfg.node_pos[l][POS_W-1:COORD_W]);
		assign prod_x = dx_s2[l] * dx_s2[l];
		assign prod_y = dy_s2[l] * dy_s2[l];
		assign d2_raw = {1'b0, sqx_s3[l]} + {1'b0, sqy_s3[l]};

		always_ff @(posedge clk) begin
			if (advance) begin
				dx_s2[l]  <= (cx_s1 >= nx) ? cx_s1 - nx : nx - cx_s1;
				dy_s2[l]  <= (cy_s1 >= ny) ? cy_s1 - ny : ny - cy_s1;
				sqx_s3[l] <= prod_x[SQ_W-1:0];
				sqy_s3[l] <= prod_y[SQ_W-1:0];
				d2_s4[l]  <= (d2_raw < MIN_DIST_SQ) ? MIN_DIST_SQ : d2_raw;
			end
		end
	end

	ibw_recip_div #(.LANES(NODE_COUNT)) u_recip (
		.clk     (clk),
		.advance (advance),
		.den     (d2_s4),
		.quo     (raw_div)
	);

	// inactive nodes drop out of the sum and get a zero weight
	for (genvar f = 0; f < FIELD_COUNT; f++) begin : g_pad
		if (f < NODE_COUNT) begin : g_used
			localparam logic [ACTIVE_W-1:0] LANE_IDX = ACTIVE_W'(f);
			assign raw_pad[f]    = (LANE_IDX < eff_count) ? raw_div[f] : '0;
			assign weight_pad[f] = norm_quo[f];
		end else begin : g_absent
			assign raw_pad[f]    = '0;
			assign weight_pad[f] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int l = 0; l < NODE_COUNT; l++) begin
				raw_s35[l] <= raw_pad[l];
				raw_s36[l] <= raw_s35[l];
			end
			pair_s35[0] <= {1'b0, raw_pad[0]} + {1'b0, raw_pad[1]};
			pair_s35[1] <= {1'b0, raw_pad[2]} + {1'b0, raw_pad[3]};
			sum_s36     <= {1'b0, pair_s35[0]} + {1'b0, pair_s35[1]};
		end
	end

	ibw_norm_div #(.LANES(NODE_COUNT)) u_norm (
		.clk     (clk),
		.advance (advance),
		.raw     (raw_s36),
		.sum     (sum_s36),
		.quo     (norm_quo)
	);

	ibw_flow_ctrl u_flow (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.advance   (advance),
		.pipe_data (weight_pad),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign weight_a = out_data[0];
	assign weight_b = out_data[1];
	assign weight_c = out_data[2];
	assign weight_d = out_data[3];

endmodule

FILE: rtl/core/ibw_cfg_regs.sv
// ibw_cfg_regs: APB-style register file for node positions and active count.
// Depends on ibw_pkg.
module ibw_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ibw_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [ibw_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [ibw_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	output ibw_pkg::cfg_t                    cfg
);
	import ibw_pkg::*;

	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.node_pos[0] <= NODE_A_RST;
			cfg_q.node_pos[1] <= NODE_B_RST;
			cfg_q.node_pos[2] <= NODE_C_RST;
			cfg_q.node_pos[3] <= NODE_D_RST;
			cfg_q.active      <= ACTIVE_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_NODE_A: cfg_q.node_pos[0] <= pwdata;
				REG_NODE_B: cfg_q.node_pos[1] <= pwdata;
				REG_NODE_C: cfg_q.node_pos[2] <= pwdata;
				REG_NODE_D: cfg_q.node_pos[3] <= pwdata;
				REG_ACTIVE: cfg_q.active <= pwdata[ACTIVE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_NODE_A: prdata = cfg_q.node_pos[0];
			REG_NODE_B: prdata = cfg_q.node_pos[1];
			REG_NODE_C: prdata = cfg_q.node_pos[2];
			REG_NODE_D: prdata = cfg_q.node_pos[3];
			REG_ACTIVE: prdata = APB_DATA_W'(cfg_q.active);
			default:    prdata = '0;
		endcase
	end

endmodule

FILE: rtl/core/ibw_recip_div.sv
// ibw_recip_div: pipelined restoring divider, floor(2^40 / d) per lane,
// one quotient bit per stage. Depends on ibw_pkg.
module ibw_recip_div #(
	parameter int LANES = ibw_pkg::DEF_NODE_COUNT
) (
	input  logic                        clk,
	input  logic                        advance,
	input  logic [ibw_pkg::DIST_W-1:0]  den [LANES],
	output logic [ibw_pkg::RAW_W-1:0]   quo [LANES]
);
	import ibw_pkg::*;

	logic [DIST_W-1:0] rem_s [RECIP_STAGES][LANES];
	logic [DIST_W-1:0] den_s [RECIP_STAGES][LANES];
	logic [RAW_W-1:0]  quo_s [RECIP_STAGES][LANES];

	for (genvar j = 0; j < RECIP_STAGES; j++) begin : g_stage
		logic [DIST_W-1:0] rem_in [LANES];
		logic [DIST_W-1:0] den_in [LANES];
		logic [RAW_W-1:0]  quo_in [LANES];
		logic [DIST_W:0]   trial  [LANES];
		logic [DIST_W:0]   diff   [LANES];
		logic              ge     [LANES];
		logic [DIST_W-1:0] rem_nx [LANES];
		logic [RAW_W-1:0]  quo_nx [LANES];

		if (j == 0) begin : g_first
			always_comb begin
				for (int l = 0; l < LANES; l++) begin
					rem_in[l] = RECIP_INIT;
					den_in[l] = den[l];
					quo_in[l] = '0;
				end
			end
		end else begin : g_next
			always_comb begin
				for (int l = 0; l < LANES; l++) begin
					rem_in[l] = rem_s[j-1][l];
					den_in[l] = den_s[j-1][l];
					quo_in[l] = quo_s[j-1][l];
				end
			end
		end

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				trial[l]  = {rem_in[l], 1'b0};
				diff[l]   = trial[l] - {1'b0, den_in[l]};
				ge[l]     = trial[l] >= {1'b0, den_in[l]};
				rem_nx[l] = ge[l] ? diff[l][DIST_W-1:0] : trial[l][DIST_W-1:0];
				quo_nx[l] = {quo_in[l][RAW_W-2:0], ge[l]};
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				rem_s[j] <= rem_nx;
				den_s[j] <= den_in;
				quo_s[j] <= quo_nx;
			end
		end
	end

	assign quo = quo_s[RECIP_STAGES-1];

endmodule

FILE: rtl/core/ibw_norm_div.sv
// ibw_norm_div: pipelined restoring divider, floor(raw * 2^15 / sum) per lane
// against a shared divisor, one quotient bit per stage. Depends on ibw_pkg.
module ibw_norm_div #(
	parameter int LANES = ibw_pkg::DEF_NODE_COUNT
) (
	input  logic                          clk,
	input  logic                          advance,
	input  logic [ibw_pkg::RAW_W-1:0]     raw [LANES],
	input  logic [ibw_pkg::SUM_W-1:0]     sum,
	output logic [ibw_pkg::WEIGHT_W-1:0]  quo [LANES]
);
	import ibw_pkg::*;

	logic [SUM_W-1:0]    rem_s [NORM_STAGES][LANES];
	logic [WEIGHT_W-1:0] quo_s [NORM_STAGES][LANES];
	logic [SUM_W-1:0]    sum_s [NORM_STAGES];

	for (genvar j = 0; j < NORM_STAGES; j++) begin : g_stage
		logic [SUM_W-1:0]    rem_in [LANES];
		logic [WEIGHT_W-1:0] quo_in [LANES];
		logic                bit_in [LANES];
		logic [SUM_W-1:0]    sum_in;
		logic [SUM_W:0]      trial  [LANES];
		logic [SUM_W:0]      diff   [LANES];
		logic                ge     [LANES];
		logic [SUM_W-1:0]    rem_nx [LANES];
		logic [WEIGHT_W-1:0] quo_nx [LANES];

		if (j == 0) begin : g_first
			// lowest raw bit is the first dividend bit below the quotient
			always_comb begin
				sum_in = sum;
				for (int l = 0; l < LANES; l++) begin
					rem_in[l] = SUM_W'(raw[l][RAW_W-1:1]);
					bit_in[l] = raw[l][0];
					quo_in[l] = '0;
				end
			end
		end else begin : g_next
			always_comb begin
				sum_in = sum_s[j-1];
				for (int l = 0; l < LANES; l++) begin
					rem_in[l] = rem_s[j-1][l];
					bit_in[l] = 1'b0;
					quo_in[l] = quo_s[j-1][l];
				end
			end
		end

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				trial[l]  = {rem_in[l], bit_in[l]};
				diff[l]   = trial[l] - {1'b0, sum_in};
				ge[l]     = trial[l] >= {1'b0, sum_in};
				rem_nx[l] = ge[l] ? diff[l][SUM_W-1:0] : trial[l][SUM_W-1:0];
				quo_nx[l] = {quo_in[l][WEIGHT_W-2:0], ge[l]};
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				rem_s[j] <= rem_nx;
				quo_s[j] <= quo_nx;
				sum_s[j] <= sum_in;
			end
		end
	end

	assign quo = quo_s[NORM_STAGES-1];

endmodule

FILE: rtl/core/ibw_flow_ctrl.sv
// ibw_flow_ctrl: valid line of the pipeline, one-entry skid buffer and output
// register; freezes the pipeline while the skid entry is occupied. Depends on ibw_pkg.
module ibw_flow_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              advance,
	input  ibw_pkg::weights_t pipe_data,
	output logic              out_valid,
	input  logic              out_stall,
	output ibw_pkg::weights_t out_data
);
	import ibw_pkg::*;

	logic [PIPE_DEPTH-1:0] valid_q;
	logic                  skid_full_q;
	weights_t              skid_data_q;
	logic                  out_valid_q;
	weights_t              out_data_q;
	logic                  pipe_last;
	logic                  load_out;

	assign advance   = !skid_full_q;
	assign in_stall  = skid_full_q;
	assign pipe_last = valid_q[PIPE_DEPTH-1];
	assign load_out  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (advance) begin
			valid_q <= {valid_q[PIPE_DEPTH-2:0], in_valid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (load_out) begin
			if (skid_full_q) begin
				out_valid_q <= 1'b1;
				skid_full_q <= 1'b0;
			end else begin
				out_valid_q <= pipe_last;
			end
		end else if (advance && pipe_last) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= skid_full_q ? skid_data_q : pipe_data;
		end
		if (!load_out && advance) begin
			skid_data_q <= pipe_data;
		end
	end

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q |-> out_valid_q)
		else $error("skid entry held without a result on the output");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_full_q) |-> $past(out_valid_q && out_stall && pipe_last))
		else $error("skid entry filled without a held output");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q && !out_stall |=> !skid_full_q && out_valid_q)
		else $error("skid entry did not move to the output");

endmodule
